@@ hw/rtl/linear_interp_resampler_unit_defines.svh @@
// Assertion macros shared by the resampler RTL.
// Define ASSERT_OFF to compile the checks away.
`ifndef LINEAR_INTERP_RESAMPLER_UNIT_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// When cond holds, prop must hold in the same cycle.
`define LIRS_ASSERT_SAME(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("resampler check failed");

// When cond holds, prop must hold in the following cycle.
`define LIRS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("resampler check failed");

`else

`define LIRS_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define LIRS_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

@@ hw/rtl/lirs_pkg.sv @@
package lirs_pkg;

  // Data and phase widths.
  localparam int SAMPLE_BITS = 18;
  localparam int DIFF_BITS   = SAMPLE_BITS + 1;
  localparam int FRAC_BITS   = 20;
  localparam int INT_BITS    = 4;
  localparam int PHASE_BITS  = FRAC_BITS + INT_BITS;
  localparam int RATIO_BITS  = 24;

  // Longest run of results that one input sample may produce.
  localparam int MAX_RUN  = 8;
  localparam int RUN_BITS = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

  localparam logic [PHASE_BITS-1:0] PHASE_ONE   = PHASE_BITS'(1) << FRAC_BITS;
  localparam logic [RATIO_BITS-1:0] RATIO_RESET = RATIO_BITS'(973924);

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 1;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RATE_RATIO = 1'b0,
    REG_MUTE       = 1'b1
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [DIFF_BITS-1:0]   diff_t;

  // Per-step control from the sequencer to the output stage.
  typedef struct packed {
    logic emit;
    logic last;
    logic mute;
  } step_ctl_t;

endpackage

@@ hw/rtl/lirs_lane.sv @@
// One interpolation lane: older + floor(diff * frac / 2^FRAC_BITS).
module lirs_lane (
  input  lirs_pkg::sample_t                   older,
  input  lirs_pkg::diff_t                     diff,
  input  logic [lirs_pkg::FRAC_BITS-1:0]      frac,
  output lirs_pkg::sample_t                   result
);

  logic signed [lirs_pkg::DIFF_BITS+lirs_pkg::FRAC_BITS:0] prod;
  logic signed [lirs_pkg::DIFF_BITS+lirs_pkg::FRAC_BITS:0] shifted;

  // The arithmetic shift of the exact product gives the floor directly.
  assign prod    = diff * $signed({1'b0, frac});
  assign shifted = prod >>> lirs_pkg::FRAC_BITS;

  // The true result lies between older and newer, so wrapping is harmless.
  assign result = lirs_pkg::sample_t'(older + shifted[lirs_pkg::SAMPLE_BITS-1:0]);

endmodule

@@ hw/rtl/lirs_merge.sv @@
// Output stage: joins the two lane results into one registered transfer.
module lirs_merge (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lirs_pkg::step_ctl_t        ctl,
  input  lirs_pkg::sample_t          lane_left,
  input  lirs_pkg::sample_t          lane_right,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [lirs_pkg::SAMPLE_BITS-1:0] out_left,
  output logic [lirs_pkg::SAMPLE_BITS-1:0] out_right,
  output logic                       out_last_of_run,
  output logic                       out_free
);

  logic              out_valid_r;
  lirs_pkg::sample_t left_r;
  lirs_pkg::sample_t right_r;
  logic              last_r;

  // The register can take a new result when empty or when its content leaves now.
  assign out_free = !out_valid_r || out_ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload, forced to zero while muted.
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      left_r  <= ctl.mute ? '0 : lane_left;
      right_r <= ctl.mute ? '0 : lane_right;
      last_r  <= ctl.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left        = left_r;
  assign out_right       = right_r;
  assign out_last_of_run = last_r;

endmodule

@@ hw/rtl/linear_interp_resampler_unit.sv @@
// Stereo linear-interpolation rate converter. Each input transfer brings one
// engine-rate sample; the block then produces zero to eight host-rate results,
// one per cycle while the output register can take them, interpolated between
// the previous and the new sample, the last one flagged by out_last_of_run. No new
// sample is taken until the last result of a run is issued; the phase accumulator,
// which advances once per result, sets the number of results. Both channels are
// computed by two lanes side by side, each with one multiplier, and an output
// register decouples the result side, so the next sample is taken while the final
// result still waits. Write rate_ratio (Q4.20) and mute_output only while idle.
`include "linear_interp_resampler_unit_defines.svh"

module linear_interp_resampler_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Configuration port.
  input  logic                                 cfg_we,
  input  logic [lirs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [lirs_pkg::RATIO_BITS-1:0]      cfg_data,
  // Input channel.
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [lirs_pkg::SAMPLE_BITS-1:0] in_sample_left,
  input  logic signed [lirs_pkg::SAMPLE_BITS-1:0] in_sample_right,
  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [lirs_pkg::SAMPLE_BITS-1:0] out_left,
  output logic signed [lirs_pkg::SAMPLE_BITS-1:0] out_right,
  output logic                                 out_last_of_run
);

  lirs_pkg::state_t                    state_r, state_nxt;
  logic [lirs_pkg::PHASE_BITS-1:0]     phase_r, phase_nxt;
  logic [lirs_pkg::RUN_BITS-1:0]       run_cnt_r, run_cnt_nxt;
  logic [lirs_pkg::RATIO_BITS-1:0]     ratio_r;
  logic                                mute_r;
  lirs_pkg::sample_t                   older_left_r, older_right_r;
  lirs_pkg::sample_t                   newer_left_r, newer_right_r;
  lirs_pkg::diff_t                     diff_left_r, diff_right_r;

  logic                                in_xfer;
  logic                                out_free;
  logic [lirs_pkg::PHASE_BITS-1:0]     phase_adj;
  logic [lirs_pkg::PHASE_BITS:0]       phase_sum;
  logic [lirs_pkg::PHASE_BITS-1:0]     phase_inc;
  logic                                step_last;
  lirs_pkg::step_ctl_t                 step_ctl;
  lirs_pkg::sample_t                   lane_left, lane_right;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= lirs_pkg::RATIO_RESET;
      mute_r  <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == lirs_pkg::REG_RATE_RATIO) begin
        ratio_r <= cfg_data;
      end
      if (cfg_index == lirs_pkg::REG_MUTE) begin
        mute_r <= cfg_data[0];
      end
    end
  end

  assign in_ready = (state_r == lirs_pkg::ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // Phase arithmetic: drop one whole sample on arrival, saturating step per result.
  assign phase_adj = (phase_r >= lirs_pkg::PHASE_ONE) ? (phase_r - lirs_pkg::PHASE_ONE)
                                                      : phase_r;
  assign phase_sum = {1'b0, phase_r} + (lirs_pkg::PHASE_BITS + 1)'(ratio_r);
  assign phase_inc = phase_sum[lirs_pkg::PHASE_BITS] ? '1
                                                     : phase_sum[lirs_pkg::PHASE_BITS-1:0];
  assign step_last = (phase_inc >= lirs_pkg::PHASE_ONE)
                  || (run_cnt_r == lirs_pkg::RUN_BITS'(lirs_pkg::MAX_RUN - 1));

  // Sequencer: next state and step control.
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    run_cnt_nxt   = run_cnt_r;
    step_ctl.emit = 1'b0;
    step_ctl.last = step_last;
    step_ctl.mute = mute_r;
    case (state_r)
      lirs_pkg::ST_IDLE: begin
        if (in_xfer) begin
          phase_nxt   = phase_adj;
          run_cnt_nxt = '0;
          if (phase_adj < lirs_pkg::PHASE_ONE) begin
            state_nxt = lirs_pkg::ST_RUN;
          end
        end
      end
      lirs_pkg::ST_RUN: begin
        if (out_free) begin
          step_ctl.emit = 1'b1;
          phase_nxt     = phase_inc;
          run_cnt_nxt   = run_cnt_r + 1'b1;
          if (step_last) begin
            state_nxt = lirs_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = lirs_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lirs_pkg::ST_IDLE;
      phase_r   <= lirs_pkg::PHASE_ONE;
      run_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      run_cnt_r <= run_cnt_nxt;
    end
  end

  // Sample history; the difference is formed once per input sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_left_r  <= '0;
      older_right_r <= '0;
      newer_left_r  <= '0;
      newer_right_r <= '0;
      diff_left_r   <= '0;
      diff_right_r  <= '0;
    end else if (in_xfer) begin
      older_left_r  <= newer_left_r;
      older_right_r <= newer_right_r;
      newer_left_r  <= in_sample_left;
      newer_right_r <= in_sample_right;
      diff_left_r   <= lirs_pkg::diff_t'(in_sample_left) - lirs_pkg::diff_t'(newer_left_r);
      diff_right_r  <= lirs_pkg::diff_t'(in_sample_right) - lirs_pkg::diff_t'(newer_right_r);
    end
  end

  // Left and right lanes.
  lirs_lane u_lane_left (
    .older  (older_left_r),
    .diff   (diff_left_r),
    .frac   (phase_r[lirs_pkg::FRAC_BITS-1:0]),
    .result (lane_left)
  );

  lirs_lane u_lane_right (
    .older  (older_right_r),
    .diff   (diff_right_r),
    .frac   (phase_r[lirs_pkg::FRAC_BITS-1:0]),
    .result (lane_right)
  );

  // Output stage.
  lirs_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (step_ctl),
    .lane_left       (lane_left),
    .lane_right      (lane_right),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_left        (out_left),
    .out_right       (out_right),
    .out_last_of_run (out_last_of_run),
    .out_free        (out_free)
  );

  // A result is only produced while the phase is inside the current interval.
  `LIRS_ASSERT_SAME(a_emit_phase, clk, rst_n, step_ctl.emit, phase_r < lirs_pkg::PHASE_ONE)

  // A run never reaches its length limit without having ended.
  `LIRS_ASSERT_SAME(a_run_bound, clk, rst_n, state_r == lirs_pkg::ST_RUN, run_cnt_r < lirs_pkg::RUN_BITS'(lirs_pkg::MAX_RUN - 1) || step_last)

  // After the flagged final result the block is ready for the next sample.
  `LIRS_ASSERT_NEXT(a_last_idle, clk, rst_n, step_ctl.emit && step_ctl.last, in_ready)

endmodule
